// ===== hdl/stta_pkg.sv =====
// Shared constants, codes and control types for the sorted term table accumulator.
`default_nettype none
package stta_pkg;

	// Table geometry
	localparam int MAX_TERMS = 32;
	localparam int IDXW      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNTW      = $clog2(MAX_TERMS + 1);
	localparam int CMPW      = (CNTW > 6) ? CNTW : 6;

	// Operation codes
	localparam logic [2:0] FUNC_INSERT  = 3'd0;
	localparam logic [2:0] FUNC_REMOVE  = 3'd1;
	localparam logic [2:0] FUNC_SEARCH  = 3'd2;
	localparam logic [2:0] FUNC_CLEAR   = 3'd3;
	localparam logic [2:0] FUNC_READOUT = 3'd4;

	// Status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_BADPOS   = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	// Broadcast command from the sequencer to every cell
	typedef struct packed {
		logic                  ins_add;  // accumulate into matching term
		logic                  ins_new;  // open a gap and place the key term
		logic                  rem;      // close the gap at pos
		logic                  rot;      // rotate the occupied cells by one
		logic signed [15:0]    key_ex;
		logic signed [31:0]    key_co;
		logic [CMPW-1:0]       pos;
		logic [CNTW-1:0]       count;
	} stta_cmd_t;

	// Reported positions and counts are taken modulo 64
	function automatic logic [5:0] to_pos6(input logic [CMPW-1:0] v);
		return v[5:0];
	endfunction

	function automatic logic [5:0] cnt6(input logic [CNTW-1:0] c);
		logic [CMPW-1:0] t;
		t = CMPW'(c);
		return t[5:0];
	endfunction

endpackage
`default_nettype wire

// ===== hdl/stta_cell.sv =====
// One table cell: holds a term, compares it with the key and shifts with its neighbours.
`default_nettype none
module stta_cell
	import stta_pkg::*;
(
	input  wire logic               clk,
	input  wire stta_cmd_t          cmd,
	input  wire logic [IDXW-1:0]    idx,
	input  wire logic               prev_gt,
	input  wire logic signed [15:0] prev_ex,
	input  wire logic signed [31:0] prev_co,
	input  wire logic signed [15:0] next_ex,
	input  wire logic signed [31:0] next_co,
	input  wire logic signed [15:0] head_ex,
	input  wire logic signed [31:0] head_co,
	output logic signed [15:0]      ex,
	output logic signed [31:0]      co,
	output logic                    gt,
	output logic                    eq,
	output logic signed [31:0]      sum,
	output logic                    rsel
);

	logic signed [15:0] ex_q;
	logic signed [31:0] co_q;
	logic               occ;
	logic               tail;
	logic [CMPW-1:0]    idx_p1;

	// Occupancy and key comparison
	always_comb begin
		occ    = CNTW'(idx) < cmd.count;
		tail   = (CNTW'(idx) + CNTW'(1)) == cmd.count;
		idx_p1 = CMPW'(idx) + CMPW'(1);
		gt     = occ && (ex_q > cmd.key_ex);
		eq     = occ && (ex_q == cmd.key_ex);
		sum    = co_q + cmd.key_co;
		rsel   = idx_p1 == cmd.pos;
	end

	// Term storage: accumulate, shift down, shift up or rotate
	always_ff @(posedge clk) begin
		if (cmd.ins_add && eq) begin
			co_q <= sum;
		end else if (cmd.ins_new && !gt) begin
			if (prev_gt) begin
				ex_q <= cmd.key_ex;
				co_q <= cmd.key_co;
			end else begin
				ex_q <= prev_ex;
				co_q <= prev_co;
			end
		end else if (cmd.rem && (idx_p1 >= cmd.pos)) begin
			ex_q <= next_ex;
			co_q <= next_co;
		end else if (cmd.rot && occ) begin
			if (tail) begin
				ex_q <= head_ex;
				co_q <= head_co;
			end else begin
				ex_q <= next_ex;
				co_q <= next_co;
			end
		end
	end

	assign ex = ex_q;
	assign co = co_q;

endmodule
`default_nettype wire

// ===== hdl/sorted_term_table_accumulator.sv =====
// Top level: sequencer, chain of term cells and registered result stage.
// Insert, remove, search, clear and unknown codes: accepted in S_IDLE, executed in S_EXEC
// once the result slot is free, result registered at its end; no new request until S_IDLE.
// Readout: an S_EXEC step, then one result per cycle, unless the output stalls, as the chain
// rotates past cell 0 (an empty table gives a single result). Output stalls hold the sequencer.
// Reset (arst_n low) empties the table and the handshake; term storage needs no clearing.
`default_nettype none
module sorted_term_table_accumulator
	import stta_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         func,
	input  wire logic signed [15:0] exponent,
	input  wire logic signed [31:0] coefficient,
	input  wire logic [5:0]         position,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [5:0]              term_position,
	output logic signed [15:0]      term_exponent,
	output logic signed [31:0]      term_coefficient,
	output logic [5:0]              term_count,
	output logic                    last
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} state_t;

	state_t             state_q;
	logic [2:0]         op_q;
	logic signed [15:0] ex_q;
	logic signed [31:0] co_q;
	logic [5:0]         pos_q;
	logic [CNTW-1:0]    count_q;
	logic [CNTW-1:0]    rd_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [5:0]         term_position_q;
	logic signed [15:0] term_exponent_q;
	logic signed [31:0] term_coefficient_q;
	logic [5:0]         term_count_q;
	logic               last_q;

	// Chain signals
	logic signed [15:0] c_ex  [MAX_TERMS];
	logic signed [31:0] c_co  [MAX_TERMS];
	logic signed [31:0] c_sum [MAX_TERMS];
	logic               c_gt  [MAX_TERMS];
	logic               c_eq  [MAX_TERMS];
	logic               c_rsel[MAX_TERMS];

	stta_cmd_t          cmd;
	logic               slot_free;
	logic               go;
	logic               any_match;
	logic               full;
	logic               bad_pos;
	logic [IDXW-1:0]    match_idx;
	logic [IDXW-1:0]    at_idx;
	logic signed [31:0] match_co;
	logic signed [31:0] match_sum;
	logic signed [15:0] rem_ex;
	logic signed [31:0] rem_co;
	logic [CMPW-1:0]    pos_c;
	logic               rd_last;

	// Next result and table count
	logic               load_out;
	logic [1:0]         res_status;
	logic [5:0]         res_pos;
	logic signed [15:0] res_ex;
	logic signed [31:0] res_co;
	logic               res_last;
	logic [CNTW-1:0]    count_d;

	assign slot_free = !out_valid_q || out_ready;
	assign go        = (state_q == S_EXEC) && slot_free;
	assign pos_c     = CMPW'(pos_q);
	assign full      = count_q == CNTW'(MAX_TERMS);
	assign bad_pos   = (pos_q == 6'd0) || (pos_c > CMPW'(count_q));
	assign rd_last   = (rd_q + CNTW'(1)) == count_q;

	// Reduce the one-hot cell flags into index and data
	always_comb begin
		any_match = 1'b0;
		match_idx = '0;
		at_idx    = '0;
		match_co  = '0;
		match_sum = '0;
		rem_ex    = '0;
		rem_co    = '0;
		for (int i = 0; i < MAX_TERMS; i++) begin
			if (c_eq[i]) begin
				any_match = 1'b1;
				match_idx = match_idx | IDXW'(i);
				match_co  = match_co | c_co[i];
				match_sum = match_sum | c_sum[i];
			end
			if (!c_gt[i] && ((i == 0) || c_gt[(i > 0) ? i - 1 : 0])) begin
				at_idx = at_idx | IDXW'(i);
			end
			if (c_rsel[i]) begin
				rem_ex = rem_ex | c_ex[i];
				rem_co = rem_co | c_co[i];
			end
		end
	end

	// Command broadcast to the chain
	always_comb begin
		cmd.ins_add = go && (op_q == FUNC_INSERT) && any_match;
		cmd.ins_new = go && (op_q == FUNC_INSERT) && !any_match && !full;
		cmd.rem     = go && (op_q == FUNC_REMOVE) && !bad_pos;
		cmd.rot     = (state_q == S_READ) && slot_free;
		cmd.key_ex  = ex_q;
		cmd.key_co  = co_q;
		cmd.pos     = pos_c;
		cmd.count   = count_q;
	end

	// Cell chain
	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
		localparam int PI = (g > 0) ? g - 1 : 0;
		localparam int NI = (g < MAX_TERMS - 1) ? g + 1 : g;
		stta_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.idx     (IDXW'(g)),
			.prev_gt ((g == 0) ? 1'b1 : c_gt[PI]),
			.prev_ex (c_ex[PI]),
			.prev_co (c_co[PI]),
			.next_ex (c_ex[NI]),
			.next_co (c_co[NI]),
			.head_ex (c_ex[0]),
			.head_co (c_co[0]),
			.ex      (c_ex[g]),
			.co      (c_co[g]),
			.gt      (c_gt[g]),
			.eq      (c_eq[g]),
			.sum     (c_sum[g]),
			.rsel    (c_rsel[g])
		);
	end

	// Result of the current step
	always_comb begin
		load_out   = 1'b0;
		res_status = ST_OK;
		res_pos    = 6'd0;
		res_ex     = '0;
		res_co     = '0;
		res_last   = 1'b1;
		count_d    = count_q;
		if (cmd.rot) begin
			// cell 0 holds the next term; the chain rotates behind it
			load_out = 1'b1;
			res_pos  = to_pos6(CMPW'(rd_q) + CMPW'(1));
			res_ex   = c_ex[0];
			res_co   = c_co[0];
			res_last = rd_last;
		end else if (go && !(op_q == FUNC_READOUT && count_q != '0)) begin
			load_out = 1'b1;
			case (op_q)
				FUNC_INSERT: begin
					if (any_match) begin
						res_pos = to_pos6(CMPW'(match_idx) + CMPW'(1));
						res_ex  = ex_q;
						res_co  = match_sum;
					end else if (full) begin
						res_status = ST_FULL;
					end else begin
						res_pos = to_pos6(CMPW'(at_idx) + CMPW'(1));
						res_ex  = ex_q;
						res_co  = co_q;
						count_d = count_q + CNTW'(1);
					end
				end
				FUNC_REMOVE: begin
					if (bad_pos) begin
						res_status = ST_BADPOS;
					end else begin
						res_pos = pos_q;
						res_ex  = rem_ex;
						res_co  = rem_co;
						count_d = count_q - CNTW'(1);
					end
				end
				FUNC_SEARCH: begin
					if (any_match) begin
						res_pos = to_pos6(CMPW'(match_idx) + CMPW'(1));
						res_ex  = ex_q;
						res_co  = match_co;
					end else begin
						res_status = ST_NOTFOUND;
					end
				end
				FUNC_CLEAR: begin
					count_d = '0;
				end
				FUNC_READOUT: begin
					// empty table
					res_status = ST_NOTFOUND;
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer, table count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rd_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				status_q           <= res_status;
				term_position_q    <= res_pos;
				term_exponent_q    <= res_ex;
				term_coefficient_q <= res_co;
				term_count_q       <= cnt6(count_d);
				last_q             <= res_last;
			end
			count_q <= count_d;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= func;
						ex_q    <= exponent;
						co_q    <= coefficient;
						pos_q   <= position;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == FUNC_READOUT && count_q != '0) begin
						rd_q    <= '0;
						state_q <= S_READ;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_READ: begin
					if (slot_free) begin
						rd_q <= rd_q + CNTW'(1);
						if (rd_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready         = (state_q == S_IDLE);
	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign term_position    = term_position_q;
	assign term_exponent    = term_exponent_q;
	assign term_coefficient = term_coefficient_q;
	assign term_count       = term_count_q;
	assign last             = last_q;

endmodule
`default_nettype wire
